/* rtl/core/slm_pkg.sv */
`timescale 1ns / 1ps

package slm_pkg;

    // Store geometry.
    localparam int SLOTS      = 1024;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS - 1);

    // Fixed field widths of the stream words.
    localparam int POS_W       = 10;
    localparam int VAL_W       = 32;
    localparam int LEN_W       = 10;
    localparam int SLOT_FLD_W  = 10;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((STATUS_W + LEN_W + SLOT_FLD_W + 7) / 8) * 8;
    localparam int CMP_W       = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [SLOT_W-1:0] FREE_SLOT = '0;
    localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_FREE = SLOT_W'(SLOTS - 2);

    // Operation codes carried in tuser.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [SLOT_W-1:0] wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } link_req_t;

    typedef struct packed {
        logic                  valid;
        logic [STATUS_W-1:0]   status;
        logic [LEN_W-1:0]      length;
        logic [SLOT_FLD_W-1:0] slot;
    } result_t;

    // A link that points past the store is treated as the end of a chain.
    function automatic logic [SLOT_W-1:0] fix_link(input logic [SLOT_W-1:0] lnk);
        return (32'(lnk) < SLOTS) ? lnk : '0;
    endfunction

endpackage

/* rtl/core/slm_ram.sv */
`timescale 1ns / 1ps

module slm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/slm_ctrl.sv */
`timescale 1ns / 1ps

module slm_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_func,
    input  logic [slm_pkg::POS_W-1:0]      in_pos,
    input  logic signed [slm_pkg::VAL_W-1:0] in_value,
    output slm_pkg::link_req_t             link_req,
    input  logic [slm_pkg::SLOT_W-1:0]     link_rdata,
    output slm_pkg::result_t               result,
    input  logic                           result_ready
);
    import slm_pkg::*;

    typedef enum logic [9:0] {
        ST_INIT     = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_INS_FREE = 10'b00_0000_0100,
        ST_INS_NEXT = 10'b00_0000_1000,
        ST_WALK     = 10'b00_0001_0000,
        ST_INS_LINK = 10'b00_0010_0000,
        ST_DEL_A    = 10'b00_0100_0000,
        ST_DEL_B    = 10'b00_1000_0000,
        ST_DEL_C    = 10'b01_0000_0000,
        ST_RESP     = 10'b10_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic                  func_reg, func_next;
    logic [POS_W-1:0]      steps_reg, steps_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic [SLOT_W-1:0]     link_rd;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      count_ext;
    logic                  ins_bad;
    logic                  del_bad;
    logic                  val_we;

    // Element values; they are kept but feed no result.
    logic [VALUE_BITS-1:0] value_mem [SLOTS];

    assign link_rd   = fix_link(link_rdata);
    assign pos_ext   = CMP_W'(in_pos);
    assign count_ext = CMP_W'(count_reg);
    assign ins_bad   = (pos_ext == '0) || (pos_ext > count_ext + CMP_W'(1));
    assign del_bad   = (pos_ext == '0) || (pos_ext > count_ext);

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        func_next   = func_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        count_next  = count_reg;
        value_next  = value_reg;
        link_req    = '0;
        in_ready    = 1'b0;
        val_we      = 1'b0;
        result      = '0;

        unique case (state_reg)
            ST_INIT: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = idx_reg;
                link_req.wr_data = (idx_reg < LAST_FREE) ? idx_reg + SLOT_W'(1) : '0;
                if (idx_reg == HEAD_SLOT) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    func_next   = in_func;
                    value_next  = VALUE_BITS'($unsigned(in_value));
                    steps_next  = in_pos - POS_W'(1);
                    cur_next    = HEAD_SLOT;
                    slot_next   = '0;
                    status_next = STATUS_OK;
                    if (in_func == FUNC_INSERT) begin
                        if (ins_bad) begin
                            status_next = STATUS_RANGE;
                            state_next  = ST_RESP;
                        end else begin
                            link_req.rd_addr = FREE_SLOT;
                            state_next       = ST_INS_FREE;
                        end
                    end else begin
                        if (del_bad) begin
                            status_next = STATUS_RANGE;
                            state_next  = ST_RESP;
                        end else begin
                            link_req.rd_addr = HEAD_SLOT;
                            state_next       = ST_WALK;
                        end
                    end
                end
            end
            ST_INS_FREE: begin
                if (link_rd == '0) begin
                    status_next = STATUS_FULL;
                    state_next  = ST_RESP;
                end else begin
                    slot_next        = link_rd;
                    link_req.rd_addr = link_rd;
                    val_we           = 1'b1;
                    state_next       = ST_INS_NEXT;
                end
            end
            ST_INS_NEXT: begin
                // Pop the slot off the free chain, then start at the data head.
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = FREE_SLOT;
                link_req.wr_data = link_rd;
                link_req.rd_addr = HEAD_SLOT;
                state_next       = ST_WALK;
            end
            ST_WALK: begin
                if (steps_reg == '0) begin
                    if (func_reg == FUNC_INSERT) begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_addr = slot_reg;
                        link_req.wr_data = link_rd;
                        state_next       = ST_INS_LINK;
                    end else begin
                        slot_next        = link_rd;
                        link_req.rd_addr = link_rd;
                        state_next       = ST_DEL_A;
                    end
                end else begin
                    cur_next         = link_rd;
                    link_req.rd_addr = link_rd;
                    steps_next       = steps_reg - POS_W'(1);
                end
            end
            ST_INS_LINK: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = cur_reg;
                link_req.wr_data = slot_reg;
                count_next       = count_reg + CNT_W'(1);
                state_next       = ST_RESP;
            end
            ST_DEL_A: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = cur_reg;
                link_req.wr_data = link_rd;
                link_req.rd_addr = FREE_SLOT;
                state_next       = ST_DEL_B;
            end
            ST_DEL_B: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = slot_reg;
                link_req.wr_data = link_rd;
                state_next       = ST_DEL_C;
            end
            ST_DEL_C: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = FREE_SLOT;
                link_req.wr_data = slot_reg;
                count_next       = count_reg - CNT_W'(1);
                state_next       = ST_RESP;
            end
            ST_RESP: begin
                result.valid  = 1'b1;
                result.status = status_reg;
                result.length = LEN_W'(count_reg);
                result.slot   = SLOT_FLD_W'(slot_reg);
                if (result_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        steps_reg  <= steps_next;
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[link_rd] <= value_reg;
        end
    end

endmodule

/* rtl/core/static_linked_list_manager.sv */
`timescale 1ns / 1ps
// Timing: a failed position check answers without touching the link memory; an insert or a
// delete at position p answers after a walk of the link chain to p (one read a cycle).
// Operations: one at a time; a new word is taken only after the last result is handed on.
// Reset: synchronous, active low; afterwards a pass over every slot rebuilds the link memory
// (free chain 1..1022, empty data list) while s_tready stays low.
module static_linked_list_manager (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position [9:0], value [41:10], zero fill above
    input  logic [slm_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], list_length [11:2], slot_used [21:12], zero fill above
    output logic [slm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import slm_pkg::*;

    link_req_t          link_req;
    logic [SLOT_W-1:0]  link_rdata;
    result_t            result;
    logic               result_ready;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // The link memory holds one next-slot pointer per slot. Slot 0 heads the
    // free chain and the last slot heads the data list.
    slm_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SLOT_W)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_req.wr_en),
        .wr_addr (link_req.wr_addr),
        .wr_data (link_req.wr_data),
        .rd_addr (link_req.rd_addr),
        .rd_data (link_rdata)
    );

    // The sequencer runs each operation as a series of read-modify-write
    // steps on the link memory; it also keeps the element count.
    slm_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (s_tuser[0]),
        .in_pos       (s_tdata[POS_W-1:0]),
        .in_value     (s_tdata[POS_W+VAL_W-1:POS_W]),
        .link_req     (link_req),
        .link_rdata   (link_rdata),
        .result       (result),
        .result_ready (result_ready)
    );

    // The output register decouples the sequencer from the result side, so
    // a new word can be taken while the previous result still waits.
    assign result_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (result_ready) begin
            m_tvalid_next = result.valid;
            if (result.valid) begin
                m_tdata_next = M_TDATA_W'({result.slot, result.length, result.status});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/slm_checker.sv */
`timescale 1ns / 1ps

module slm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [slm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import slm_pkg::*;

    // No result may appear in the cycle after reset is applied.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word shown right after reset");

    // A failed operation reports no slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != STATUS_OK) |-> m_tdata[21:12] == '0)
        else $error("failed operation reports a slot");

    // A successful operation never hands out the free head or an undefined status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == STATUS_OK && m_tdata[21:12] != '0)
                  || m_tdata[1:0] == STATUS_RANGE || m_tdata[1:0] == STATUS_FULL)
        else $error("bad status or slot in result word");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The sequencer works on one word at a time, so it cannot take two in a row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input word taken in back-to-back cycles");

endmodule

bind static_linked_list_manager slm_checker u_slm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
